// ----- sv/tsc_pkg.sv -----
// Shared types, codes and reset values for the triggered sample capture block.
package tsc_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned CfgAddrWidth     = 4;
  localparam int unsigned CfgDataWidth     = 32;

  localparam logic [15:0] SampleCountReset    = 16'd100;
  localparam logic [15:0] SampleIntervalReset = 16'd10;
  localparam logic [15:0] TrigLevelReset      = 16'd50;

  typedef enum logic [1:0] {
    REG_SAMPLE_COUNT    = 2'd0,
    REG_SAMPLE_INTERVAL = 2'd1,
    REG_TRIG_LEVEL      = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_ARM      = 3'd0,
    MODE_START    = 3'd1,
    MODE_CANCEL   = 3'd2,
    MODE_SETPOINT = 3'd3,
    MODE_SAMPLE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_CAPT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CFG   = 2'd1,
    ST_NO_CANCEL = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] sample_count;
    logic [15:0] sample_interval;
    logic [15:0] trig_level;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic signed [15:0] baseline;
    logic [15:0]        samples_taken;
  } ctl_state_t;

  typedef struct packed {
    status_t     status;
    phase_t      capture_state;
    logic        recorded;
    logic [15:0] sample_index;
    logic        began;
    logic        ended;
  } result_t;

endpackage

// ----- sv/tsc_regs.sv -----
// APB-style configuration register file for the triggered sample capture block.
module tsc_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tsc_pkg::CfgAddrWidth-1:0]    paddr,
  input  logic [tsc_pkg::CfgDataWidth-1:0]    pwdata,
  output logic [tsc_pkg::CfgDataWidth-1:0]    prdata,
  output logic                                pready,
  output tsc_pkg::cfg_t                       cfg
);

  tsc_pkg::cfg_t     cfg_r;
  tsc_pkg::cfg_t     cfg_nxt;
  tsc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = tsc_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        tsc_pkg::REG_SAMPLE_COUNT:    cfg_nxt.sample_count    = pwdata[15:0];
        tsc_pkg::REG_SAMPLE_INTERVAL: cfg_nxt.sample_interval = pwdata[15:0];
        tsc_pkg::REG_TRIG_LEVEL:      cfg_nxt.trig_level      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tsc_pkg::REG_SAMPLE_COUNT:    prdata = {16'd0, cfg_r.sample_count};
      tsc_pkg::REG_SAMPLE_INTERVAL: prdata = {16'd0, cfg_r.sample_interval};
      tsc_pkg::REG_TRIG_LEVEL:      prdata = {16'd0, cfg_r.trig_level};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count    <= tsc_pkg::SampleCountReset;
      cfg_r.sample_interval <= tsc_pkg::SampleIntervalReset;
      cfg_r.trig_level      <= tsc_pkg::TrigLevelReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/tsc_step.sv -----
// Per-beat event decode: next capture state and result fields for one item.
module tsc_step #(
  parameter int unsigned TIME_WIDTH = tsc_pkg::TimeWidthDefault
) (
  input  logic [2:0]            mode,
  input  logic signed [15:0]    baseline_setpoint,
  input  logic signed [15:0]    setpoint,
  input  logic [TIME_WIDTH-1:0] time_ms,
  input  tsc_pkg::cfg_t         cfg,
  input  tsc_pkg::ctl_state_t   st,
  input  logic [TIME_WIDTH-1:0] next_due,
  output tsc_pkg::ctl_state_t   st_nxt,
  output logic [TIME_WIDTH-1:0] next_due_nxt,
  output tsc_pkg::result_t      res
);

  logic              cfg_ok;
  logic signed [16:0] diff;
  logic [16:0]       abs_diff;
  logic [15:0]       taken_inc;

  assign cfg_ok    = (cfg.sample_count != 16'd0) && (cfg.sample_interval != 16'd0);
  assign diff      = 17'(setpoint) - 17'(st.baseline);
  assign abs_diff  = diff[16] ? 17'(-diff) : 17'(diff);
  assign taken_inc = st.samples_taken + 16'd1;

  always_comb begin
    st_nxt       = st;
    next_due_nxt = next_due;
    res          = '0;
    res.status   = tsc_pkg::ST_OK;
    unique case (tsc_pkg::mode_t'(mode))
      tsc_pkg::MODE_ARM: begin
        if (!cfg_ok) begin
          res.status = tsc_pkg::ST_BAD_CFG;
        end else begin
          st_nxt.baseline      = baseline_setpoint;
          st_nxt.samples_taken = '0;
          st_nxt.phase         = tsc_pkg::PH_ARMED;
          next_due_nxt         = '0;
        end
      end
      tsc_pkg::MODE_START: begin
        if (!cfg_ok) begin
          res.status = tsc_pkg::ST_BAD_CFG;
        end else begin
          st_nxt.phase         = tsc_pkg::PH_CAPT;
          st_nxt.samples_taken = '0;
          next_due_nxt         = time_ms;
          res.began            = 1'b1;
        end
      end
      tsc_pkg::MODE_CANCEL: begin
        if (st.phase == tsc_pkg::PH_IDLE) begin
          res.status = tsc_pkg::ST_NO_CANCEL;
        end else begin
          st_nxt.phase         = tsc_pkg::PH_IDLE;
          st_nxt.samples_taken = '0;
        end
      end
      tsc_pkg::MODE_SETPOINT: begin
        if (st.phase == tsc_pkg::PH_ARMED && abs_diff >= {1'b0, cfg.trig_level}) begin
          st_nxt.phase         = tsc_pkg::PH_CAPT;
          st_nxt.samples_taken = '0;
          next_due_nxt         = time_ms;
          res.began            = 1'b1;
        end
      end
      tsc_pkg::MODE_SAMPLE: begin
        if (st.phase == tsc_pkg::PH_CAPT && time_ms >= next_due) begin
          res.recorded         = 1'b1;
          res.sample_index     = st.samples_taken;
          st_nxt.samples_taken = taken_inc;
          next_due_nxt         = next_due + TIME_WIDTH'(cfg.sample_interval);
          // end on reaching the count, or when the index counter wraps
          if (taken_inc >= cfg.sample_count || taken_inc == 16'd0) begin
            st_nxt.phase         = tsc_pkg::PH_IDLE;
            st_nxt.samples_taken = '0;
            res.ended            = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.capture_state = st_nxt.phase;
  end

endmodule

// ----- sv/triggered_sample_capture.sv -----
// Top level of the triggered sample capture controller.
//
// Usage:
//   Input channel (in_*): one event beat per item; in_mode selects arm, start,
//   cancel, setpoint check or sample. Every accepted beat yields exactly one
//   result beat on the output channel (out_*), in order.
//   Configuration port: APB-style, registers sample_count, sample_interval
//   and the trigger threshold at byte addresses 0, 4 and 8; pready is high.
//   Write registers only while no items are in flight.
// Pipeline:
//   An accepted beat is held in the input register, decoded from there and
//   its result is registered in the result register, which drives out_valid.
//   One beat per cycle is sustained while out_stall is low; the state update
//   is computed combinationally from the capture registers in the decode cycle.
// Reset (rst_n low, synchronous): phase idle, baseline, sample counter and
//   due time cleared, registers back to 100, 10 and 50, both channels empty.
// Stall: while out_stall is high a valid result beat holds; the input
//   register still takes one more beat, after which in_stall rises.
module triggered_sample_capture #(
  parameter int unsigned TIME_WIDTH = tsc_pkg::TimeWidthDefault
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsc_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [tsc_pkg::CfgDataWidth-1:0] pwdata,
  output logic [tsc_pkg::CfgDataWidth-1:0] prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_mode,
  input  logic signed [15:0]               in_baseline_setpoint,
  input  logic signed [15:0]               in_setpoint,
  input  logic [TIME_WIDTH-1:0]            in_time_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [1:0]                       out_capture_state,
  output logic                             out_recorded,
  output logic [15:0]                      out_sample_index,
  output logic                             out_began,
  output logic                             out_ended
);

  tsc_pkg::cfg_t cfg;

  tsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: holds one beat waiting for decode.
  logic                  in_vld_r;
  logic [2:0]            in_mode_r;
  logic signed [15:0]    in_base_r;
  logic signed [15:0]    in_sp_r;
  logic [TIME_WIDTH-1:0] in_time_r;

  // Capture state.
  tsc_pkg::ctl_state_t   st_r;
  tsc_pkg::ctl_state_t   st_nxt;
  logic [TIME_WIDTH-1:0] due_r;
  logic [TIME_WIDTH-1:0] due_nxt;

  // Result register.
  logic                  out_vld_r;
  tsc_pkg::result_t      res_r;
  tsc_pkg::result_t      res_nxt;

  logic advance;   // decode the held beat into the result register
  logic in_take;

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  // The input register frees up whenever its beat advances.
  assign in_stall = in_vld_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  tsc_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .mode              (in_mode_r),
    .baseline_setpoint (in_base_r),
    .setpoint          (in_sp_r),
    .time_ms           (in_time_r),
    .cfg               (cfg),
    .st                (st_r),
    .next_due          (due_r),
    .st_nxt            (st_nxt),
    .next_due_nxt      (due_nxt),
    .res               (res_nxt)
  );

  // Hold the input payload unless a new beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_mode;
      in_base_r <= in_baseline_setpoint;
      in_sp_r   <= in_setpoint;
      in_time_r <= in_time_ms;
    end
  end

  // Advance capture state once per decoded beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= tsc_pkg::PH_IDLE;
      st_r.baseline      <= '0;
      st_r.samples_taken <= '0;
      due_r              <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      due_r <= due_nxt;
    end
  end

  // Result register: drop the beat once taken, hold it while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (~out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = res_r.status;
  assign out_capture_state = res_r.capture_state;
  assign out_recorded      = res_r.recorded;
  assign out_sample_index  = res_r.sample_index;
  assign out_began         = res_r.began;
  assign out_ended         = res_r.ended;

endmodule
